@@ hdl/priority_sorted_medium_stack_assert.svh @@
// Assertion macros for the priority sorted medium stack checker.
`ifndef PRIORITY_SORTED_MEDIUM_STACK_ASSERT_SVH
`define PRIORITY_SORTED_MEDIUM_STACK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PSMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/psms_pkg.sv @@
// Shared types and codes for the priority sorted medium stack.
`default_nettype none

package psms_pkg;

    localparam logic [1:0] KIND_ENTER = 2'd0;
    localparam logic [1:0] KIND_EXIT  = 2'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic match;
        logic prio_lt;
        logic prio_gt;
    } t_cmp;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN     = 5'b00010,
        S_DECIDE   = 5'b00100,
        S_SHIFT_UP = 5'b01000,
        S_SHIFT_DN = 5'b10000
    } t_state;

endpackage

`default_nettype wire

@@ hdl/psms_store.sv @@
// Slot register file: one write port, one indexed read port, fixed top read.
`default_nettype none

module psms_store #(
    parameter int DEPTH     = 8,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16,
    parameter int IDX_W     = 3,
    parameter int CNT_W     = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_we,
    input  wire logic [IDX_W-1:0]     i_waddr,
    input  wire logic [PRIO_BITS-1:0] i_wprio,
    input  wire logic [TAG_BITS-1:0]  i_wtag,
    input  wire logic [CNT_W-1:0]     i_raddr,
    output logic      [PRIO_BITS-1:0] o_rprio,
    output logic      [TAG_BITS-1:0]  o_rtag,
    output logic      [PRIO_BITS-1:0] o_top_prio,
    output logic      [TAG_BITS-1:0]  o_top_tag
);

    logic [PRIO_BITS-1:0] r_prio [DEPTH];
    logic [TAG_BITS-1:0]  r_tag  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_prio[i] <= '1;
                r_tag[i]  <= '1;
            end
        end else if (i_we) begin
            r_prio[i_waddr] <= i_wprio;
            r_tag[i_waddr]  <= i_wtag;
        end
    end

    always_comb begin
        if (i_raddr < CNT_W'(DEPTH)) begin
            o_rprio = r_prio[i_raddr[IDX_W-1:0]];
            o_rtag  = r_tag[i_raddr[IDX_W-1:0]];
        end else begin
            o_rprio = '1;
            o_rtag  = '1;
        end
    end

    assign o_top_prio = r_prio[0];
    assign o_top_tag  = r_tag[0];

endmodule

`default_nettype wire

@@ hdl/psms_cmp.sv @@
// Shared slot comparator: entry match and priority order against the request.
`default_nettype none

module psms_cmp
    import psms_pkg::*;
#(
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  wire logic [PRIO_BITS-1:0] i_slot_prio,
    input  wire logic [TAG_BITS-1:0]  i_slot_tag,
    input  wire logic [PRIO_BITS-1:0] i_req_prio,
    input  wire logic [TAG_BITS-1:0]  i_req_tag,
    output t_cmp                      o_cmp
);

    logic w_prio_eq;

    assign w_prio_eq     = (i_slot_prio == i_req_prio);
    assign o_cmp.match   = w_prio_eq && (i_slot_tag == i_req_tag);
    assign o_cmp.prio_lt = (i_slot_prio < i_req_prio);
    assign o_cmp.prio_gt = !w_prio_eq && !o_cmp.prio_lt;

endmodule

`default_nettype wire

@@ hdl/priority_sorted_medium_stack.sv @@
// Top level of the priority sorted medium stack with its slot sequencer.
//
// A request is taken when start is high and busy is low. The block keeps up to
// DEPTH (priority, tag) entries sorted by ascending priority, lowest in slot 0.
// One slot is read per cycle through a single read port and one comparator:
// the scan visits slots 0 through F for fill count F, a decision state
// follows, then an enter moves each entry behind the insertion point down
// one slot per cycle and then writes the new entry, and an exit moves each
// entry behind the match up one slot per cycle with a clearing write of the
// last slot. The result is registered after the last state, and busy stays
// high until the edge that ends the o_valid cycle. o_valid is high for
// exactly one cycle and the receiver cannot stall it. Overflow and not-found
// leave the list as it was.
`default_nettype none

module priority_sorted_medium_stack
    import psms_pkg::*;
#(
    parameter int DEPTH     = 8,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_kind,
    input  wire logic [PRIO_BITS-1:0]         i_prio,
    input  wire logic [TAG_BITS-1:0]          i_tag,
    output logic                              o_valid,
    output logic      [1:0]                   o_status,
    output logic                              o_hit_is_true,
    output logic                              o_entry_present,
    output logic      [PRIO_BITS-1:0]         o_top_prio,
    output logic      [TAG_BITS-1:0]          o_top_tag,
    output logic                              o_is_vacuum,
    output logic      [$clog2(DEPTH+1)-1:0]   o_fill_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_match, n_match;
    logic             r_found, n_found;
    logic             r_gt_found, n_gt_found;
    logic             r_hit, n_hit;
    logic [1:0]       r_status, n_status;
    logic             r_valid, n_valid;

    logic [1:0]           r_kind;
    logic [PRIO_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]  r_tag;

    logic                 w_we;
    logic [CNT_W-1:0]     w_waddr;
    logic [PRIO_BITS-1:0] w_wprio;
    logic [TAG_BITS-1:0]  w_wtag;
    logic [CNT_W-1:0]     w_raddr;
    logic [PRIO_BITS-1:0] w_rprio;
    logic [TAG_BITS-1:0]  w_rtag;
    logic [PRIO_BITS-1:0] w_top_prio;
    logic [TAG_BITS-1:0]  w_top_tag;
    t_cmp                 w_cmp;
    logic                 w_accept;

    assign w_accept = start && !busy;

    psms_store #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .TAG_BITS  (TAG_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_we),
        .i_waddr    (w_waddr[IDX_W-1:0]),
        .i_wprio    (w_wprio),
        .i_wtag     (w_wtag),
        .i_raddr    (w_raddr),
        .o_rprio    (w_rprio),
        .o_rtag     (w_rtag),
        .o_top_prio (w_top_prio),
        .o_top_tag  (w_top_tag)
    );

    psms_cmp #(
        .PRIO_BITS (PRIO_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_cmp (
        .i_slot_prio (w_rprio),
        .i_slot_tag  (w_rtag),
        .i_req_prio  (r_prio),
        .i_req_tag   (r_tag),
        .o_cmp       (w_cmp)
    );

    always_comb begin
        case (r_state)
            S_SHIFT_UP: w_raddr = r_idx - CNT_W'(1);
            S_SHIFT_DN: w_raddr = r_idx + CNT_W'(1);
            default:    w_raddr = r_idx;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_match    = r_match;
        n_found    = r_found;
        n_gt_found = r_gt_found;
        n_hit      = r_hit;
        n_status   = r_status;
        n_valid    = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wprio    = w_rprio;
        w_wtag     = w_rtag;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state    = S_SCAN;
                    n_idx      = '0;
                    n_pos      = r_cnt;
                    n_match    = '0;
                    n_found    = 1'b0;
                    n_gt_found = 1'b0;
                    n_status   = ST_OK;
                end
            end
            S_SCAN: begin
                if (r_idx == '0) begin
                    n_hit = !w_cmp.prio_lt;
                end
                if (r_idx == r_cnt) begin
                    n_state = S_DECIDE;
                end else begin
                    if (w_cmp.match && !r_found) begin
                        n_found = 1'b1;
                        n_match = r_idx;
                    end
                    if (w_cmp.prio_gt && !r_gt_found) begin
                        n_gt_found = 1'b1;
                        n_pos      = r_idx;
                    end
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_DECIDE: begin
                if (r_kind == KIND_ENTER) begin
                    if (r_cnt == CNT_W'(DEPTH)) begin
                        n_status = ST_OVERFLOW;
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                    end else begin
                        n_idx   = r_cnt;
                        n_state = S_SHIFT_UP;
                    end
                end else if (r_kind == KIND_EXIT) begin
                    if (!r_found) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                    end else begin
                        n_idx   = r_match;
                        n_state = S_SHIFT_DN;
                    end
                end else begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            S_SHIFT_UP: begin
                w_we = 1'b1;
                if (r_idx == r_pos) begin
                    w_waddr = r_pos;
                    w_wprio = r_prio;
                    w_wtag  = r_tag;
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_idx = r_idx - CNT_W'(1);
                end
            end
            S_SHIFT_DN: begin
                w_we = 1'b1;
                if ((r_idx + CNT_W'(1)) == r_cnt) begin
                    w_wprio = '1;
                    w_wtag  = '1;
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_pos      <= '0;
            r_match    <= '0;
            r_found    <= 1'b0;
            r_gt_found <= 1'b0;
            r_hit      <= 1'b0;
            r_status   <= ST_OK;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_pos      <= n_pos;
            r_match    <= n_match;
            r_found    <= n_found;
            r_gt_found <= n_gt_found;
            r_hit      <= n_hit;
            r_status   <= n_status;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_prio <= i_prio;
            r_tag  <= i_tag;
        end
    end

    assign busy            = (r_state != S_IDLE) || r_valid;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_hit_is_true   = r_hit;
    assign o_entry_present = r_found;
    assign o_top_prio      = w_top_prio;
    assign o_is_vacuum     = (w_top_prio == '1);
    assign o_top_tag       = o_is_vacuum ? '1 : w_top_tag;
    assign o_fill_count    = r_cnt;

endmodule

`default_nettype wire

@@ hdl/psms_checker.sv @@
// Port-level checker for the priority sorted medium stack and its bind.
`default_nettype none

`include "priority_sorted_medium_stack_assert.svh"

module psms_port_assert
    import psms_pkg::*;
#(
    parameter int DEPTH     = 8,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_valid,
    input wire logic [1:0]                 o_status,
    input wire logic [PRIO_BITS-1:0]       o_top_prio,
    input wire logic [TAG_BITS-1:0]        o_top_tag,
    input wire logic                       o_is_vacuum,
    input wire logic [$clog2(DEPTH+1)-1:0] o_fill_count
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic w_overflow;
    logic w_full;

    assign w_overflow = o_valid && (o_status == ST_OVERFLOW);
    assign w_full     = (o_fill_count == FILL_W'(DEPTH));

    `PSMS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `PSMS_ASSERT_NOW(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `PSMS_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)
    `PSMS_ASSERT_NOW(a_vacuum_tag, i_clk, i_rst_n, o_valid && o_is_vacuum, &{o_top_prio, o_top_tag})
    `PSMS_ASSERT_NOW(a_overflow_full, i_clk, i_rst_n, w_overflow, w_full)

endmodule

bind priority_sorted_medium_stack psms_port_assert #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .TAG_BITS  (TAG_BITS)
) u_psms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_top_prio   (o_top_prio),
    .o_top_tag    (o_top_tag),
    .o_is_vacuum  (o_is_vacuum),
    .o_fill_count (o_fill_count)
);

`default_nettype wire
